>>> design/sha256_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// antecedent implies consequent in the same cycle, reset disables
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Constants, types and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int QueueDepth = 4;
   localparam int QueueAw    = 2;

   typedef logic [31:0] word_type;

   // queue entry: one accepted item
   typedef struct packed {
      logic       finish;
      logic [7:0] data;
   } item_type;

   typedef enum logic [2:0] {
      BE_ABSORB,
      BE_ROUND,
      BE_FOLD,
      BE_PAD,
      BE_EMIT
   } be_state_type;

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_h(input logic [2:0] idx);
      word_type h;
      case (idx)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type ror(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

>>> design/sha_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts items and queues them for the compression back end.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     q_valid,
   input  logic     q_ready,
   output item_type q_item
);

   item_type          mem_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueAw:0]   cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready = (cnt_ff != (QueueAw+1)'(QueueDepth));
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = mem_ff[rd_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

>>> design/sha_back.sv
// ----------------------------------------------------------------------------
// SHA-256 back end
// Block buffering, padding, 64-round compression and digest emission.
// ----------------------------------------------------------------------------
module sha_back import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   output logic        out_valid,
   input  logic        out_ready,
   output word_type    out_word,
   output logic [2:0]  out_index,
   output logic        out_last
);

   be_state_type state_ff, state_in;
   word_type     h_ff [8];
   word_type     v_ff [8];
   word_type     w_ff [16];       // message schedule window
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff;
   logic [63:0]  total_ff;
   logic [5:0]   rnd_ff;
   logic [2:0]   emit_ff;
   logic         final_ff;        // compression is the last of a finish
   logic         pad2_ff;         // a length-only block still follows

   // byte into the schedule window; bytes enter big-endian per word
   logic         wr_en;
   logic [7:0]   wr_byte;
   word_type     t1, t2, s0, s1, wnew, e, a;

   assign e  = v_ff[4];
   assign a  = v_ff[0];
   assign t1 = v_ff[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
             + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(rnd_ff) + w_ff[0];
   assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
             + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign s0 = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1 = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign wnew = s1 + w_ff[9] + s0 + w_ff[0];

   assign out_valid = (state_ff == BE_EMIT);
   assign out_word  = h_ff[emit_ff];
   assign out_index = emit_ff;
   assign out_last  = (emit_ff == 3'd7);
   assign q_ready   = (state_ff == BE_ABSORB);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      wr_en    = 1'b0;
      wr_byte  = q_item.data;
      case (state_ff)
         BE_ABSORB: begin
            if (q_valid) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + 6'd1;
               if (q_item.finish) begin
                  wr_byte = 8'h80;
                  // marker in the last slot fills the block at once
                  state_in = (fill_ff == 6'd63) ? BE_ROUND : BE_PAD;
               end else if (fill_ff == 6'd63) begin
                  state_in = BE_ROUND;
               end
            end
         end
         BE_PAD: begin
            // zeros, then, unless a length-only block follows, the big-endian length in bytes 56..63
            wr_en   = 1'b1;
            fill_in = fill_ff + 6'd1;
            wr_byte = 8'h00;
            if (!pad2_ff && fill_ff >= 6'd56) begin
               wr_byte = total_ff[8'(7 - fill_ff[2:0]) * 8 +: 8];
            end
            if (fill_ff == 6'd63) begin
               state_in = BE_ROUND;
            end
         end
         BE_ROUND: begin
            if (rnd_ff == 6'd63) begin
               state_in = BE_FOLD;
            end
         end
         BE_FOLD: begin
            if (!final_ff) state_in = BE_ABSORB;
            else if (pad2_ff) state_in = BE_PAD;
            else state_in = BE_EMIT;
         end
         BE_EMIT: begin
            if (out_ready && emit_ff == 3'd7) begin
               state_in = BE_ABSORB;
               fill_in  = '0;
            end
         end
         default: state_in = BE_ABSORB;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_ABSORB;
         fill_ff  <= '0;
         bits_ff  <= '0;
         rnd_ff   <= '0;
         emit_ff  <= '0;
         final_ff <= 1'b0;
         pad2_ff  <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (state_ff == BE_ABSORB && q_valid && q_item.finish) begin
            total_ff <= bits_ff + {55'd0, fill_ff, 3'd0};
            final_ff <= 1'b1;
            pad2_ff  <= (fill_ff >= 6'd56);
         end
         if (state_ff == BE_ROUND) begin
            rnd_ff <= rnd_ff + 6'd1;
         end
         if (state_ff == BE_FOLD) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
            if (!final_ff) bits_ff <= bits_ff + 64'd512;
            pad2_ff <= 1'b0;
         end
         if (state_ff == BE_EMIT && out_ready) begin
            emit_ff <= emit_ff + 3'd1;
            if (emit_ff == 3'd7) begin
               for (int i = 0; i < 8; i++) h_ff[i] <= init_h(3'(i));
               bits_ff  <= '0;
               final_ff <= 1'b0;
            end
         end
      end
   end

   // working variables and schedule window
   always_ff @(posedge clock) begin
      if (wr_en) begin
         // shift bytes in; 16 words x 4 bytes form the block
         for (int i = 0; i < 15; i++) w_ff[i] <= {w_ff[i][23:0], w_ff[i+1][31:24]};
         w_ff[15] <= {w_ff[15][23:0], wr_byte};
      end else if (state_ff == BE_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnew;
      end
      if (state_in == BE_ROUND && state_ff != BE_ROUND) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (state_ff == BE_ROUND) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

endmodule

>>> design/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide SHA-256 with a queued front end and an iterative round core.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item per handshake: an absorb item holds one
//   message byte in req_tdata; an item with req_tuser high finishes the
//   message (req_tdata ignored).
//   rsp_ channel returns eight items per finish, digest words most
//   significant first; rsp_tdata packs word then index, rsp_tlast marks the
//   eighth word.
// Throughput: absorb items are taken one per cycle while the back end
//   absorbs; the 64th byte of a block starts the rounds and a fold on the
//   single round unit. A finish adds padding bytes up to the block end, one
//   per cycle, then one or two compressions, then eight output words.
// A four-item queue in the front feeds the back so that input
//   keeps flowing briefly while a block compresses.
// Reset sets the initial hash values and empties the queue.
// A stalled receiver simply holds the current digest word; no item is lost.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index
   output logic        rsp_tlast
);

   item_type   in_item, q_item;
   logic       q_valid, q_ready;
   word_type   word;
   logic [2:0] idx;

   assign in_item.finish = req_tuser;
   assign in_item.data   = req_tdata;

   sha_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item,
      .q_valid, .q_ready, .q_item
   );

   sha_back u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_item,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(word), .out_index(idx), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, idx, word};

endmodule

>>> design/sha_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the top-level ports for digest word order, tlast, hold under stall and pad bits.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   `SHA_ASSERT_IMP(a_last_idx, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[34:32] == 3'd7), "tlast not on word seven")
   `SHA_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "digest word dropped under stall")
   `SHA_ASSERT_NEXT(a_seq, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1, "digest words out of order")
   `SHA_ASSERT_IMP(a_pad, clock, reset, rsp_tvalid, rsp_tdata[39:35] == 5'd0, "pad bits set")

endmodule

bind sha256_stream_hasher sha_checker u_checker (.*);
